### rtl/core/mkld_pkg.sv
// Shared types, constants and the letter table of the Morse key letter decoder.
package mkld_pkg;

    localparam int MAX_SYMBOLS_DEF = 4;
    localparam int QUEUE_DEPTH     = 2;
    localparam int LETTER_COUNT    = 26;
    localparam int INDEX_W         = 5;
    localparam int TOTAL_W         = 3;
    localparam int TICK_W          = 16;
    localparam int CFG_INDEX_W     = 2;
    localparam int IN_TDATA_W      = 8;
    localparam int OUT_TDATA_W     = 16;

    localparam logic [TICK_W-1:0] TICK_TOP         = 16'hFFFF;
    localparam logic [TICK_W-1:0] DASH_TICKS_RESET = 16'd31249;
    localparam logic [TICK_W-1:0] GAP_TICKS_RESET  = 16'd62499;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DASH_TICKS = 2'd0,
        CFG_GAP_TICKS  = 2'd1
    } cfg_index_t;

    // Symbols per letter, a through z.
    localparam logic [2:0] LETTER_LEN [LETTER_COUNT] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };

    // Bit i set means symbol i of the letter is a dash.
    localparam logic [3:0] LETTER_DASH [LETTER_COUNT] = '{
        4'h2, 4'h1, 4'h5, 4'h1, 4'h0, 4'h4, 4'h3, 4'h0, 4'h0, 4'hE, 4'h5, 4'h2, 4'h3,
        4'h1, 4'h7, 4'h6, 4'hB, 4'h2, 4'h0, 4'h1, 4'h4, 4'h8, 4'h6, 4'h9, 4'hD, 4'h3
    };

endpackage

### rtl/core/mkld_front.sv
// Front end: configuration registers, key timing and symbol collection per letter.
module mkld_front #(
    parameter int MAX_SYMBOLS = mkld_pkg::MAX_SYMBOLS_DEF,
    parameter int COUNT_W     = $clog2(MAX_SYMBOLS + 2)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mkld_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mkld_pkg::TICK_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                key_released,
    input  logic                                q_full,
    output logic                                push,
    output logic [MAX_SYMBOLS-1:0]              push_bits,
    output logic [COUNT_W-1:0]                  push_count
);

    localparam int IDX_W = $clog2(MAX_SYMBOLS);

    logic [mkld_pkg::TICK_W-1:0] dash_ticks_reg, dash_ticks_next;
    logic [mkld_pkg::TICK_W-1:0] gap_ticks_reg, gap_ticks_next;
    logic                        key_held_reg, key_held_next;
    logic                        mark_is_dot_reg, mark_is_dot_next;
    logic [mkld_pkg::TICK_W-1:0] tick_reg, tick_next;
    logic                        counting_reg, counting_next;
    logic [MAX_SYMBOLS-1:0]      bits_reg, bits_next;
    logic [COUNT_W-1:0]          count_reg, count_next;
    logic                        accept;
    logic                        letter_end;
    logic [MAX_SYMBOLS-1:0]      bits_app;
    logic [COUNT_W-1:0]          count_app;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        dash_ticks_next = dash_ticks_reg;
        gap_ticks_next  = gap_ticks_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                mkld_pkg::CFG_DASH_TICKS: dash_ticks_next = cfg_data;
                mkld_pkg::CFG_GAP_TICKS:  gap_ticks_next  = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // One tick of key timing; decisions see the counter after any restart in this tick.
    always_comb
    begin
        key_held_next    = key_held_reg;
        mark_is_dot_next = mark_is_dot_reg;
        tick_next        = tick_reg;
        counting_next    = counting_reg;
        bits_app         = bits_reg;
        count_app        = count_reg;
        letter_end       = 1'b0;

        if (key_released)
        begin
            if (key_held_reg)
            begin
                key_held_next    = 1'b0;
                tick_next        = '0;
                counting_next    = 1'b1;
                mark_is_dot_next = 1'b1;
                if (count_reg < COUNT_W'(MAX_SYMBOLS))
                begin
                    if (!mark_is_dot_reg)
                    begin
                        bits_app[count_reg[IDX_W-1:0]] = 1'b1;
                    end
                    count_app = count_reg + 1'b1;
                end
                else
                begin
                    count_app = COUNT_W'(MAX_SYMBOLS + 1);
                end
            end
            if (counting_next && tick_next >= gap_ticks_reg)
            begin
                tick_next     = '0;
                counting_next = 1'b0;
                letter_end    = 1'b1;
            end
        end
        else
        begin
            if (!key_held_reg)
            begin
                tick_next     = '0;
                counting_next = 1'b1;
            end
            key_held_next = 1'b1;
            if (mark_is_dot_reg && tick_next >= dash_ticks_reg)
            begin
                tick_next        = '0;
                counting_next    = 1'b0;
                mark_is_dot_next = 1'b0;
            end
        end

        if (counting_next && tick_next != mkld_pkg::TICK_TOP)
        begin
            tick_next = tick_next + 1'b1;
        end

        bits_next  = letter_end ? '0 : bits_app;
        count_next = letter_end ? '0 : count_app;
    end

    assign push       = accept && letter_end;
    assign push_bits  = bits_app;
    assign push_count = count_app;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dash_ticks_reg  <= mkld_pkg::DASH_TICKS_RESET;
            gap_ticks_reg   <= mkld_pkg::GAP_TICKS_RESET;
            key_held_reg    <= 1'b0;
            mark_is_dot_reg <= 1'b1;
            tick_reg        <= '0;
            counting_reg    <= 1'b0;
            bits_reg        <= '0;
            count_reg       <= '0;
        end
        else
        begin
            dash_ticks_reg <= dash_ticks_next;
            gap_ticks_reg  <= gap_ticks_next;
            if (accept)
            begin
                key_held_reg    <= key_held_next;
                mark_is_dot_reg <= mark_is_dot_next;
                tick_reg        <= tick_next;
                counting_reg    <= counting_next;
                bits_reg        <= bits_next;
                count_reg       <= count_next;
            end
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_SYMBOLS + 1))
        else $error("symbol count out of range");

    a_push_clears: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (count_reg == '0 && bits_reg == '0 && !counting_reg))
        else $error("letter end did not clear the symbol buffer");

endmodule

### rtl/core/mkld_queue.sv
// Short queue of finished letters between the front end and the matcher.
module mkld_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mkld_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             q_valid,
    output logic [WIDTH-1:0] q_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             do_pop;

    assign full    = level_reg == LVL_W'(DEPTH);
    assign q_valid = level_reg != '0;
    assign q_data  = mem[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        level_next = level_reg + LVL_W'(push) - LVL_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("word pushed into a full queue");

    a_level_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !do_pop) |=> level_reg == $past(level_reg) + 1'b1)
        else $error("queue level did not follow a push");

endmodule

### rtl/core/mkld_back.sv
// Back end: matches a finished symbol pattern against the letter table and holds the result.
module mkld_back #(
    parameter int MAX_SYMBOLS = mkld_pkg::MAX_SYMBOLS_DEF,
    parameter int COUNT_W     = $clog2(MAX_SYMBOLS + 2)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  logic [MAX_SYMBOLS-1:0]             q_bits,
    input  logic [COUNT_W-1:0]                 q_count,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               letter_found,
    output logic [mkld_pkg::INDEX_W-1:0]       letter_index,
    output logic [mkld_pkg::TOTAL_W-1:0]       symbol_total
);

    logic                         valid_reg, valid_next;
    logic                         found_reg;
    logic [mkld_pkg::INDEX_W-1:0] index_reg;
    logic [mkld_pkg::TOTAL_W-1:0] total_reg;
    logic                         match_found;
    logic [mkld_pkg::INDEX_W-1:0] match_index;

    // Table patterns are distinct, so at most one entry hits.
    always_comb
    begin
        match_found = 1'b0;
        match_index = '0;
        for (int k = 0; k < mkld_pkg::LETTER_COUNT; k++)
        begin
            if (q_count == COUNT_W'(mkld_pkg::LETTER_LEN[k])
                && q_bits == MAX_SYMBOLS'(mkld_pkg::LETTER_DASH[k]))
            begin
                match_found = 1'b1;
                match_index = mkld_pkg::INDEX_W'(k);
            end
        end
    end

    assign pop        = q_valid && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            found_reg <= match_found;
            index_reg <= match_index;
            total_reg <= q_count[mkld_pkg::TOTAL_W-1:0];
        end
    end

    assign out_valid    = valid_reg;
    assign letter_found = found_reg;
    assign letter_index = index_reg;
    assign symbol_total = total_reg;

    a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && found_reg) |-> (total_reg != '0 && total_reg <= 3'd4))
        else $error("matched letter with impossible symbol total");

endmodule

### rtl/core/morse_key_letter_decoder_top.sv
// Top level of the Morse key letter decoder.
//
// Each slave word is one prescaled timer tick with the sampled key level in
// s_tdata[0] (1 released, 0 pressed). A press that reaches dash_ticks is a dash,
// otherwise a dot; the mark is stored on release. A release that lasts
// gap_ticks ends the letter and one master word is produced with the letter
// index, a found flag and the symbol count.
// The configuration channel writes dash_ticks (index 0) and gap_ticks (index 1)
// and is always ready; writes belong to idle periods.
// Throughput: one tick per cycle while s_tready is high. The letter passes the
// front end, the two-entry letter queue and the table match into the output
// register before the master word appears.
// Reset clears the key timing and the symbol buffer and loads the default
// thresholds. When the master side stalls, finished letters collect in the
// output register and the queue; s_tready drops only when the queue is full.
module morse_key_letter_decoder_top #(
    parameter int MAX_SYMBOLS = mkld_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mkld_pkg::IN_TDATA_W-1:0]     s_tdata,   // [0] key_released, rest zero
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mkld_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [0] letter_found, [5:1] letter_index,
                                                           // [8:6] symbol_total, rest zero
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mkld_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mkld_pkg::TICK_W-1:0]         cfg_data
);

    localparam int COUNT_W = $clog2(MAX_SYMBOLS + 2);
    localparam int ENTRY_W = MAX_SYMBOLS + COUNT_W;

    logic                         push;
    logic [MAX_SYMBOLS-1:0]       push_bits;
    logic [COUNT_W-1:0]           push_count;
    logic                         q_full;
    logic                         q_valid;
    logic [ENTRY_W-1:0]           q_data;
    logic                         pop;
    logic                         letter_found;
    logic [mkld_pkg::INDEX_W-1:0] letter_index;
    logic [mkld_pkg::TOTAL_W-1:0] symbol_total;

    mkld_front #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .COUNT_W     (COUNT_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .key_released (s_tdata[0]),
        .q_full       (q_full),
        .push         (push),
        .push_bits    (push_bits),
        .push_count   (push_count)
    );

    mkld_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (mkld_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_count, push_bits}),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    mkld_back #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .COUNT_W     (COUNT_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_bits       (q_data[MAX_SYMBOLS-1:0]),
        .q_count      (q_data[ENTRY_W-1:MAX_SYMBOLS]),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .letter_found (letter_found),
        .letter_index (letter_index),
        .symbol_total (symbol_total)
    );

    assign m_tdata = {7'd0, symbol_total, letter_index, letter_found};

endmodule
